// File: rtl/dtlf_pkg.sv
// package: shared types and constants for the decision tree leaf finder
`timescale 1ns / 1ps
`default_nettype none
package dtlf_pkg;

  localparam int NODE_W     = 10;
  localparam int FSEL_W     = 6;
  localparam int DATA_W     = 32;
  localparam int FEAT_SLOTS = 64;

  localparam int MAX_NODES_DEF    = 1024;
  localparam int NUM_FEATURES_DEF = 64;
  localparam int VALUE_WIDTH_DEF  = 32;

  typedef enum logic [1:0] {
    ACT_NODE     = 2'd0,
    ACT_FEAT     = 2'd1,
    ACT_CLASSIFY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_NODE = 2'd1,
    ST_FEAT = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    action_t                  action;
    logic [NODE_W-1:0]        node_index;
    logic [NODE_W-1:0]        left_node;
    logic [NODE_W-1:0]        right_node;
    logic [FSEL_W-1:0]        split_feature;
    logic signed [DATA_W-1:0] split_threshold;
    logic [FSEL_W-1:0]        feature_index;
    logic signed [DATA_W-1:0] feature_value;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] leaf_index;
    logic              lost;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/dtlf_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module dtlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/decision_tree_leaf_finder.sv
// top level: decision tree walk over node and feature memories
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_data (in_t)
//  out     | output    | out_valid/out_ready| out_data (out_t)
//  cfg     | input     | cfg_we             | cfg_wdata (root index)
//
// node and feature writes are taken in the idle state
// classify reads the root node on accept, then for each inner node its feature and the next node
// the walk is bounded by MAX_NODES visits
// reset clears control state only; memory contents stay undefined until written
// the output register holds a result while the next transaction is accepted
`timescale 1ns / 1ps
`default_nettype none
module decision_tree_leaf_finder
  import dtlf_pkg::*;
#(
  parameter int MAX_NODES    = MAX_NODES_DEF,
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [NODE_W-1:0] cfg_wdata
);

  localparam int CMP_W       = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int FEAT_DEPTH  = (NUM_FEATURES < FEAT_SLOTS) ? NUM_FEATURES : FEAT_SLOTS;
  localparam int FEAT_AW     = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam int VIS_W       = $clog2(MAX_NODES);
  localparam int NODE_WORD_W = 2 * NODE_W + FSEL_W + CMP_W;
  localparam int NODE_DEPTH  = 1 << NODE_W;

  state_t state_r, state_nxt;

  logic [NODE_W-1:0] root_r;
  logic [NODE_W-1:0] cur_node_r;
  logic [VIS_W-1:0]  visits_r;
  logic              oob_r;
  logic [NODE_W-1:0] res_leaf_r;
  logic              res_lost_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic                   node_we, node_re;
  logic [NODE_W-1:0]      node_raddr;
  logic [NODE_WORD_W-1:0] node_wdata, node_rdata;
  logic                   feat_we, feat_re;
  logic [CMP_W-1:0]       feat_rdata;
  logic                   out_load;
  logic                   take;

  logic [CMP_W-1:0]  nd_thr;
  logic [FSEL_W-1:0] nd_feat;
  logic [NODE_W-1:0] nd_left, nd_right;
  logic              is_leaf, step_last, go_left;
  logic [CMP_W-1:0]  feat_val;
  logic [NODE_W-1:0] next_node;

  assign node_wdata = {in_data.left_node, in_data.right_node, in_data.split_feature,
                       in_data.split_threshold[CMP_W-1:0]};

  assign nd_thr   = node_rdata[CMP_W-1:0];
  assign nd_feat  = node_rdata[CMP_W +: FSEL_W];
  assign nd_right = node_rdata[CMP_W+FSEL_W +: NODE_W];
  assign nd_left  = node_rdata[CMP_W+FSEL_W+NODE_W +: NODE_W];

  assign is_leaf   = (nd_left == '0) && (nd_right == '0);
  assign step_last = (visits_r == VIS_W'(MAX_NODES - 1));
  assign feat_val  = oob_r ? '0 : feat_rdata;
  assign go_left   = $signed(feat_val) <= $signed(nd_thr);
  assign next_node = go_left ? nd_left : nd_right;
  assign take      = in_valid && in_ready;

  dtlf_ram #(
    .WIDTH(NODE_WORD_W),
    .DEPTH(NODE_DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (node_we),
    .waddr(in_data.node_index),
    .wdata(node_wdata),
    .re   (node_re),
    .raddr(node_raddr),
    .rdata(node_rdata)
  );

  dtlf_ram #(
    .WIDTH(CMP_W),
    .DEPTH(FEAT_DEPTH)
  ) u_feat_ram (
    .clk  (clk),
    .we   (feat_we),
    .waddr(in_data.feature_index[FEAT_AW-1:0]),
    .wdata(in_data.feature_value[CMP_W-1:0]),
    .re   (feat_re),
    .raddr(nd_feat[FEAT_AW-1:0]),
    .rdata(feat_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && in_data.action == ACT_CLASSIFY) begin
          state_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        if (is_leaf || step_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FEAT;
        end
      end
      ST_FEAT: begin
        state_nxt = ST_NODE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_raddr = root_r;
    feat_we    = 1'b0;
    feat_re    = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        node_we  = in_valid && in_data.action == ACT_NODE;
        node_re  = in_valid && in_data.action == ACT_CLASSIFY;
        feat_we  = in_valid && in_data.action == ACT_FEAT
                   && (32'(in_data.feature_index) < NUM_FEATURES);
      end
      ST_NODE: begin
        feat_re = !is_leaf && !step_last;
      end
      ST_FEAT: begin
        node_re    = 1'b1;
        node_raddr = next_node;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && take) begin
      cur_node_r <= root_r;
      visits_r   <= '0;
    end
    if (state_r == ST_NODE) begin
      oob_r <= 32'(nd_feat) >= NUM_FEATURES;
      if (is_leaf) begin
        res_leaf_r <= cur_node_r;
        res_lost_r <= 1'b0;
      end else if (step_last) begin
        res_leaf_r <= '0;
        res_lost_r <= 1'b1;
      end
    end
    if (state_r == ST_FEAT) begin
      cur_node_r <= next_node;
      visits_r   <= visits_r + 1'b1;
    end
    if (out_load) begin
      out_data_r.leaf_index <= res_leaf_r;
      out_data_r.lost       <= res_lost_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_classify_reads_node: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_data.action == ACT_CLASSIFY) |=> state_r == ST_NODE)
    else $error("classify transaction did not start a node read");

  a_feat_after_node: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FEAT |-> $past(state_r) == ST_NODE && !$past(is_leaf))
    else $error("feature step without a preceding inner node");

  a_lost_zero_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_lost_r) |-> res_leaf_r == '0)
    else $error("lost result carries a nonzero leaf index");

  a_no_input_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NODE || state_r == ST_FEAT) |-> !node_we && !feat_we)
    else $error("memory write during a walk");

endmodule
`default_nettype wire
